[rtl/rbb_pkg.sv]
// package: widths, constants, cordic angle table and helper types for the box bounds core
package rbb_pkg;

  localparam int TRIG_BITS       = 16;
  localparam int ROTATION_STAGES = 16;

  // cordic working format: Q2.30 in a wide signed word
  localparam int CW = 34;
  localparam int ZW = 34;

  localparam int EW   = 34;  // scaled edge width (Q.8)
  localparam int PW   = 28;
  localparam int TW   = TRIG_BITS + 2;  // signed cos/sin width
  localparam int ACCW = 64;

  localparam logic signed [23:0] TURN_Q8    = 24'sd92160;
  localparam logic signed [23:0] QUARTER_Q8 = 24'sd23040;
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
  localparam logic signed [35:0] DEG_TO_RAD_K = 36'sd4797524517;

  localparam logic signed [24:0] OUT_MAX = 25'sd16777215;
  localparam logic signed [24:0] OUT_MIN = -25'sd16777216;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = ZW'(64'sd843314857);
      1: v = ZW'(64'sd497837829);
      2: v = ZW'(64'sd263043837);
      3: v = ZW'(64'sd133525159);
      4: v = ZW'(64'sd67021687);
      5: v = ZW'(64'sd33543516);
      6: v = ZW'(64'sd16775851);
      7: v = ZW'(64'sd8388437);
      8: v = ZW'(64'sd4194283);
      9: v = ZW'(64'sd2097149);
      default: v = ZW'(64'sd1) <<< (30 - i);
    endcase
    return v;
  endfunction

  // operands carried along the chain beside the cordic state
  typedef struct packed {
    logic signed [EW-1:0] edge_l;
    logic signed [EW-1:0] edge_r;
    logic signed [EW-1:0] edge_t;
    logic signed [EW-1:0] edge_b;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic                 xsp;
    logic                 ysp;
    logic                 zero_ang;
    logic [1:0]           quad;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

endpackage

[rtl/rbb_cell.sv]
// one cordic rotation cell with a register stage and the side payload carried along
module rbb_cell
  import rbb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [4:0]          shift,
  input  logic signed [ZW-1:0] atan_val,
  input  logic                vld_in,
  input  rot_t                rot_in,
  input  side_t               side_in,
  output logic                vld_out,
  output rot_t                rot_out,
  output side_t               side_out
);

  logic  vld_r;
  rot_t  rot_r, rot_nxt;
  side_t side_r;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx = rot_in.y >>> shift;
    dy = rot_in.x >>> shift;
    if (rot_in.z >= 0) begin
      rot_nxt.x = rot_in.x - dx;
      rot_nxt.y = rot_in.y + dy;
      rot_nxt.z = rot_in.z - atan_val;
    end else begin
      rot_nxt.x = rot_in.x + dx;
      rot_nxt.y = rot_in.y - dy;
      rot_nxt.z = rot_in.z + atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      rot_r  <= rot_nxt;
      side_r <= side_in;
    end
  end

  assign vld_out  = vld_r;
  assign rot_out  = rot_r;
  assign side_out = side_r;

endmodule

[rtl/rbb_bound.sv]
// one bound: two products plus position, a half-unit bias, truncation toward zero and saturation, two stages
module rbb_bound
  import rbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [TW-1:0]  cs,
  input  logic signed [TW-1:0]  sn,
  input  logic signed [EW-1:0]  e1,
  input  logic signed [EW-1:0]  e2,
  input  logic                  neg2,
  input  logic signed [PW-1:0]  pos,
  output logic signed [24:0]    bound
);

  logic signed [ACCW-1:0] p1_r, p2_r, pos_r;
  logic signed [ACCW-1:0] acc, q;
  logic signed [24:0] sat;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= ACCW'(cs) * ACCW'(e1);
      p2_r  <= neg2 ? -(ACCW'(sn) * ACCW'(e2)) : ACCW'(sn) * ACCW'(e2);
      pos_r <= ACCW'(pos) <<< TRIG_BITS;
    end
  end

  always_comb begin
    acc = p1_r + p2_r + pos_r + (ACCW'(1) <<< (7 + TRIG_BITS));
    // truncate toward zero: bias negatives before the floor shift
    if (acc < 0) q = (acc + ((ACCW'(1) <<< (8 + TRIG_BITS)) - 1)) >>> (8 + TRIG_BITS);
    else q = acc >>> (8 + TRIG_BITS);
    if (q > ACCW'(OUT_MAX)) sat = OUT_MAX;
    else if (q < ACCW'(OUT_MIN)) sat = OUT_MIN;
    else sat = q[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) bound <= sat;
  end

endmodule

[rtl/rotated_box_bounds_core.sv]
// top level: rotated, scaled sprite box to axis-aligned pixel bounds
// datapath order: scaled edges and angle, quadrant, radians, rotation cells, edge selection, bound products, bound sum
// throughput: one transaction per cycle while the output is not stalled; the whole pipeline advances together
// stall: a held result freezes every stage, out_tready low backs up to in_tready
// reset: rst_n synchronous active low clears the valid flags of every stage, ready right after
module rotated_box_bounds_core
  import rbb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // box_left[15:0] box_top[31:16] box_right[47:32] box_bottom[63:48]
  // pos_x[91:64] pos_y[119:92] scale_x[135:120] scale_y[151:136] angle_deg[175:152]
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // bound_left[24:0] bound_right[49:25] bound_top[74:50] bound_bottom[99:75], zero fill to 104
  output logic [103:0] out_tdata
);

  localparam int N = ROTATION_STAGES;
  localparam int NV = N + 6;

  // global enable: pipeline moves when the output slot is free or being taken
  logic en;
  logic [NV-1:0] vld;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld[NV-1];

  // field unpack
  logic signed [15:0] bl, bt, br, bb, sx, sy;
  logic signed [27:0] px, py;
  logic signed [23:0] ang;
  assign bl  = in_tdata[15:0];
  assign bt  = in_tdata[31:16];
  assign br  = in_tdata[47:32];
  assign bb  = in_tdata[63:48];
  assign px  = in_tdata[91:64];
  assign py  = in_tdata[119:92];
  assign sx  = in_tdata[135:120];
  assign sy  = in_tdata[151:136];
  assign ang = in_tdata[175:152];

  // stage 0: scaled edges; angle offset by 92 turns so it is never negative,
  // then whole quarter turns counted by a reciprocal multiply (23040 = 512 * 45)
  localparam logic [24:0] ANG_OFS = 25'(92 * TURN_Q8);
  localparam logic [14:0] INV45   = 15'd23302;  // ceil(2^20 / 45)
  side_t s0_r;
  logic [24:0] t0_r;
  logic [9:0]  qq0_r;
  logic [24:0] ang_ofs;
  logic [29:0] qprod;
  always_comb begin
    ang_ofs = 25'(ang) + ANG_OFS;
    qprod   = 30'(ang_ofs[24:9]) * 30'(INV45);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.edge_l   <= EW'(bl) * EW'(sx);
      s0_r.edge_r   <= (EW'(br) + EW'(1)) * EW'(sx) - EW'(256);
      s0_r.edge_t   <= EW'(bt) * EW'(sy);
      s0_r.edge_b   <= (EW'(bb) + EW'(1)) * EW'(sy) - EW'(256);
      s0_r.pos_x    <= px;
      s0_r.pos_y    <= py;
      s0_r.xsp      <= !sx[15];
      s0_r.ysp      <= !sy[15];
      s0_r.zero_ang <= (ang == 0);
      s0_r.quad     <= 2'd0;
      t0_r          <= ang_ofs;
      qq0_r         <= qprod[29:20];
    end
  end

  // stage 1: quadrant from the quarter count, residual within the quadrant
  side_t s1_r, s1_nxt;
  logic signed [23:0] r1_r;
  logic [24:0] rr;
  always_comb begin
    rr          = t0_r - 25'(qq0_r) * 25'(QUARTER_Q8);
    s1_nxt      = s0_r;
    s1_nxt.quad = s0_r.zero_ang ? 2'd0 : qq0_r[1:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      r1_r <= 24'(rr);
    end
  end

  // stage 2: degrees to radians Q2.30
  side_t s2_r;
  logic signed [ZW-1:0] z2_r;
  logic signed [63:0] zprod;
  assign zprod = (64'(r1_r) * 64'(DEG_TO_RAD_K) + 64'sd32768) >>> 16;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s1_r;
      z2_r <= zprod[ZW-1:0];
    end
  end

  // chain of rotation cells
  rot_t  rot_c [N+1];
  side_t side_c [N+1];
  logic  vld_c [N+1];
  assign rot_c[0].x = GAIN_Q30;
  assign rot_c[0].y = '0;
  assign rot_c[0].z = z2_r;
  assign side_c[0]  = s2_r;
  assign vld_c[0]   = vld[2];

  for (genvar i = 0; i < N; i++) begin : g_cell
    rbb_cell u_cell (
      .clk, .rst_n, .en,
      .shift   (5'(i)),
      .atan_val(atan_q30(i)),
      .vld_in  (vld_c[i]),
      .rot_in  (rot_c[i]),
      .side_in (side_c[i]),
      .vld_out (vld_c[i+1]),
      .rot_out (rot_c[i+1]),
      .side_out(side_c[i+1])
    );
  end

  // stage after chain: round cos/sin and quadrant rotate, pick edges
  logic signed [CW-1:0] cr, sr;
  logic signed [TW-1:0] c0, s0, cs_n, sn_n;
  side_t sf;
  assign sf = side_c[N];
  always_comb begin
    cr = (rot_c[N].x + (CW'(1) <<< (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);
    sr = (rot_c[N].y + (CW'(1) <<< (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);
    c0 = cr[TW-1:0];
    s0 = sr[TW-1:0];
    if (sf.zero_ang) begin
      cs_n = TW'(1) <<< TRIG_BITS;
      sn_n = '0;
    end else begin
      case (sf.quad)
        2'd1:    begin cs_n = -s0; sn_n = c0;  end
        2'd2:    begin cs_n = -c0; sn_n = -s0; end
        2'd3:    begin cs_n = s0;  sn_n = -c0; end
        default: begin cs_n = c0;  sn_n = s0;  end
      endcase
    end
  end

  logic q12, q23, xs12, sx23, ys12, ys23;
  assign q12  = (sf.quad == 2'd1) || (sf.quad == 2'd2);
  assign q23  = (sf.quad == 2'd2) || (sf.quad == 2'd3);
  assign xs12 = sf.xsp ^ q12;
  assign sx23 = sf.xsp ^ q23;
  assign ys12 = sf.ysp ^ q12;
  assign ys23 = sf.ysp ^ q23;

  logic signed [TW-1:0] cs_r, sn_r;
  logic signed [EW-1:0] e_l1, e_l2, e_r1, e_r2, e_t1, e_t2, e_b1, e_b2;
  logic signed [PW-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_n;
      sn_r <= sn_n;
      e_l1 <= xs12 ? sf.edge_l : sf.edge_r;
      e_l2 <= ys23 ? sf.edge_t : sf.edge_b;
      e_r1 <= xs12 ? sf.edge_r : sf.edge_l;
      e_r2 <= ys23 ? sf.edge_b : sf.edge_t;
      e_t1 <= ys12 ? sf.edge_t : sf.edge_b;
      e_t2 <= sx23 ? sf.edge_r : sf.edge_l;
      e_b1 <= ys12 ? sf.edge_b : sf.edge_t;
      e_b2 <= sx23 ? sf.edge_l : sf.edge_r;
      px_r <= sf.pos_x;
      py_r <= sf.pos_y;
    end
  end

  // final two stages: products, then sum and saturate
  logic signed [24:0] b_l, b_r, b_t, b_b;
  rbb_bound u_left  (.clk, .en, .cs(cs_r), .sn(sn_r), .e1(e_l1), .e2(e_l2), .neg2(1'b0),
                     .pos(px_r), .bound(b_l));
  rbb_bound u_right (.clk, .en, .cs(cs_r), .sn(sn_r), .e1(e_r1), .e2(e_r2), .neg2(1'b0),
                     .pos(px_r), .bound(b_r));
  rbb_bound u_top   (.clk, .en, .cs(cs_r), .sn(sn_r), .e1(e_t1), .e2(e_t2), .neg2(1'b1),
                     .pos(py_r), .bound(b_t));
  rbb_bound u_bot   (.clk, .en, .cs(cs_r), .sn(sn_r), .e1(e_b1), .e2(e_b2), .neg2(1'b1),
                     .pos(py_r), .bound(b_b));

  assign out_tdata = {4'b0, b_b, b_t, b_r, b_l};

  // valid shift line: stages 0..2, chain output, then three tail stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[2:0]      <= '0;
      vld[NV-1:N+3] <= '0;
    end else if (en) begin
      vld[0]        <= in_tvalid;
      vld[1]        <= vld[0];
      vld[2]        <= vld[1];
      vld[N+3]      <= vld_c[N];
      vld[NV-1:N+4] <= vld[NV-2:N+3];
    end
  end
  for (genvar k = 3; k < N + 3; k++) begin : g_vtap
    assign vld[k] = vld_c[k-2];
  end

endmodule

[rtl/rbb_checker.sv]
// port-level checker for the box bounds core, bound to the top level
module rbb_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready) else $error("ready while output stalled");
  ap_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("not ready with empty output");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  ap_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:100] == 4'b0) else $error("pad bits set");

endmodule

bind rotated_box_bounds_core rbb_checker u_rbb_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
